@@ hw/rtl/mdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared types, widths and codes for the momentum desaturation torquer:
// transaction payloads, configuration register indexes and the control word
// that the microcode sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package mdt_pkg;

  // Sample width of field, momentum and dipole values (Q1.(DATA_WIDTH-1)).
  localparam int DATA_WIDTH = 16;

  // Configuration register widths.
  localparam int GAIN_W     = 16;
  localparam int THR_W      = 15;
  localparam int TICK_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Datapath widths, derived from the sample, gain and threshold widths.
  localparam int PRE_SHIFT  = (DATA_WIDTH > 16) ? DATA_WIDTH - 16 : 0;
  localparam int POST_SHIFT = DATA_WIDTH - 1 - PRE_SHIFT + 8;
  localparam int MUL_W      = (DATA_WIDTH + 1 > GAIN_W + 1) ? DATA_WIDTH + 1 : GAIN_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIFF_W     = 2 * DATA_WIDTH - PRE_SHIFT + 1;
  localparam int ACC_W      = DIFF_W + GAIN_W + 1;
  localparam int RND_W      = ACC_W + 1;
  localparam int CMP_W      = (DATA_WIDTH > THR_W) ? DATA_WIDTH : THR_W;

  // Microprogram sizing.
  localparam int STEP_W     = 5;

  typedef logic signed [DATA_WIDTH-1:0] sample_t;
  typedef logic signed [MUL_W-1:0]      mul_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [RND_W-1:0]      rnd_t;
  typedef logic [STEP_W-1:0]            step_t;

  // Rounding and saturation constants.
  localparam rnd_t RND_HALF = rnd_t'(1) << (POST_SHIFT - 1);
  localparam rnd_t SAT_MAX  = rnd_t'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}));
  localparam rnd_t SAT_MIN  = rnd_t'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}));

  // Input transaction payload.
  typedef struct packed {
    sample_t field_x;
    sample_t field_y;
    sample_t field_z;
    sample_t momentum_x;
    sample_t momentum_y;
    sample_t momentum_z;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    sample_t dipole_x;
    sample_t dipole_y;
    sample_t dipole_z;
    logic    active;
    logic    measuring;
  } out_item_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN    = 3'd0,
    REG_ON_THR  = 3'd1,
    REG_OFF_THR = 3'd2,
    REG_PERIOD  = 3'd3,
    REG_MEASURE = 3'd4
  } cfg_reg_t;

  // Multiplier operand A sources.
  typedef enum logic [2:0] {
    MA_H0, MA_H1, MA_H2, MA_DHI, MA_DLO
  } mul_a_sel_t;

  // Multiplier operand B sources.
  typedef enum logic [1:0] {
    MB_M0, MB_M1, MB_M2, MB_GAIN
  } mul_b_sel_t;

  // Difference register operations.
  typedef enum logic [1:0] {
    D_NONE, D_LOAD, D_SUB
  } d_op_t;

  // Scaled accumulator operations.
  typedef enum logic [1:0] {
    A_NONE, A_LOAD_HI, A_ADD
  } a_op_t;

  // Output axis selected by a dipole write.
  typedef enum logic [1:0] {
    AX_X, AX_Y, AX_Z
  } axis_t;

  // Jump conditions.
  typedef enum logic {
    J_NONE, J_SKIP
  } jump_t;

  // One microcode control word.
  typedef struct packed {
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    d_op_t      d_op;
    a_op_t      a_op;
    logic       dip_wr;
    axis_t      axis;
    logic       dip_clr;
    jump_t      jump;
    step_t      target;
    logic       done;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    mul_a:   MA_H0,
    mul_b:   MB_M0,
    d_op:    D_NONE,
    a_op:    A_NONE,
    dip_wr:  1'b0,
    axis:    AX_X,
    dip_clr: 1'b0,
    jump:    J_NONE,
    target:  '0,
    done:    1'b0
  };

  // Sequencer status toward the top level.
  typedef struct packed {
    logic busy;
    logic finish;
  } seq_stat_t;

endpackage

@@ hw/rtl/mdt_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_sequencer
// Step counter and microcode ROM. Each step issues one control word to the
// datapath; step zero jumps straight to the final step when no dipole is due.
// ----------------------------------------------------------------------------
module mdt_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              skip,
  input  logic              out_free,
  output mdt_pkg::ctrl_t    ctrl,
  output mdt_pkg::seq_stat_t stat
);
  import mdt_pkg::*;

  localparam step_t LAST_STEP = step_t'(17);

  // Build one control word.
  function automatic ctrl_t cw(mul_a_sel_t a, mul_b_sel_t b, d_op_t d, a_op_t ao,
                               logic wr, axis_t ax);
    ctrl_t w;
    w        = CTRL_NOP;
    w.mul_a  = a;
    w.mul_b  = b;
    w.d_op   = d;
    w.a_op   = ao;
    w.dip_wr = wr;
    w.axis   = ax;
    return w;
  endfunction

  // Microprogram. The multiplier result of a step is consumed by the next.
  // Axis x: h1*m2 - h2*m1, axis y: h2*m0 - h0*m2, axis z: h0*m1 - h1*m0.
  function automatic ctrl_t ucode_rom(step_t s);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (s)
      5'd0: begin
        w         = cw(MA_H1, MB_M2, D_NONE, A_NONE, 1'b0, AX_X);
        w.dip_clr = 1'b1;
        w.jump    = J_SKIP;
        w.target  = LAST_STEP;
      end
      5'd1:  w = cw(MA_H2,  MB_M1,   D_LOAD, A_NONE,    1'b0, AX_X);
      5'd2:  w = cw(MA_H0,  MB_M0,   D_SUB,  A_NONE,    1'b0, AX_X);
      5'd3:  w = cw(MA_DHI, MB_GAIN, D_NONE, A_NONE,    1'b0, AX_X);
      5'd4:  w = cw(MA_DLO, MB_GAIN, D_NONE, A_LOAD_HI, 1'b0, AX_X);
      5'd5:  w = cw(MA_H2,  MB_M0,   D_NONE, A_ADD,     1'b0, AX_X);
      5'd6:  w = cw(MA_H0,  MB_M2,   D_LOAD, A_NONE,    1'b1, AX_X);
      5'd7:  w = cw(MA_H0,  MB_M0,   D_SUB,  A_NONE,    1'b0, AX_Y);
      5'd8:  w = cw(MA_DHI, MB_GAIN, D_NONE, A_NONE,    1'b0, AX_Y);
      5'd9:  w = cw(MA_DLO, MB_GAIN, D_NONE, A_LOAD_HI, 1'b0, AX_Y);
      5'd10: w = cw(MA_H0,  MB_M1,   D_NONE, A_ADD,     1'b0, AX_Y);
      5'd11: w = cw(MA_H1,  MB_M0,   D_LOAD, A_NONE,    1'b1, AX_Y);
      5'd12: w = cw(MA_H0,  MB_M0,   D_SUB,  A_NONE,    1'b0, AX_Z);
      5'd13: w = cw(MA_DHI, MB_GAIN, D_NONE, A_NONE,    1'b0, AX_Z);
      5'd14: w = cw(MA_DLO, MB_GAIN, D_NONE, A_LOAD_HI, 1'b0, AX_Z);
      5'd15: w = cw(MA_H0,  MB_M0,   D_NONE, A_ADD,     1'b0, AX_Z);
      5'd16: w = cw(MA_H0,  MB_M0,   D_NONE, A_NONE,    1'b1, AX_Z);
      5'd17: w.done = 1'b1;
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

  logic  busy_r, busy_nxt;
  step_t step_r, step_nxt;
  ctrl_t word;
  logic  finish;

  // Fetch the control word of the current step.
  assign word   = ucode_rom(step_r);
  assign finish = busy_r && word.done && out_free;

  // Next step: advance, take the jump, or hold on the final step.
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
      end
    end else if (word.done) begin
      if (out_free) begin
        busy_nxt = 1'b0;
      end
    end else if (word.jump == J_SKIP && skip) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath sees no operations while the sequencer is idle.
  assign ctrl        = busy_r ? word : CTRL_NOP;
  assign stat.busy   = busy_r;
  assign stat.finish = finish;

endmodule

@@ hw/rtl/mdt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_datapath
// Shared multiplier, difference and scaled accumulators, rounding and
// saturation, and the held field and dipole registers.
// ----------------------------------------------------------------------------
module mdt_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mdt_pkg::in_item_t               in_data,
  input  logic                            ld_mom,
  input  logic                            ld_held,
  input  logic [mdt_pkg::GAIN_W-1:0]      gain,
  input  mdt_pkg::ctrl_t                  ctrl,
  output mdt_pkg::sample_t                dip_x,
  output mdt_pkg::sample_t                dip_y,
  output mdt_pkg::sample_t                dip_z
);
  import mdt_pkg::*;

  sample_t held_r [3];
  sample_t mom_r  [3];
  sample_t dip_r  [3];
  sample_t dip_nxt[3];
  prod_t   prod_r, prod_nxt;
  diff_t   d_r, d_nxt;
  acc_t    acc_r, acc_nxt;
  mul_t    op_a, op_b;
  prod_t   prod_sh;
  acc_t    prod_ext;
  rnd_t    rnd_sum, rnd_sh;
  sample_t sat_val;

  // Held field resets to zero; momentum is reloaded with every transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r[0] <= '0;
      held_r[1] <= '0;
      held_r[2] <= '0;
    end else if (ld_held) begin
      held_r[0] <= in_data.field_x;
      held_r[1] <= in_data.field_y;
      held_r[2] <= in_data.field_z;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_mom) begin
      mom_r[0] <= in_data.momentum_x;
      mom_r[1] <= in_data.momentum_y;
      mom_r[2] <= in_data.momentum_z;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    unique case (ctrl.mul_a)
      MA_H0:   op_a = mul_t'(held_r[0]);
      MA_H1:   op_a = mul_t'(held_r[1]);
      MA_H2:   op_a = mul_t'(held_r[2]);
      MA_DHI:  op_a = mul_t'($signed(d_r[DIFF_W-1:DATA_WIDTH]));
      MA_DLO:  op_a = mul_t'($signed({1'b0, d_r[DATA_WIDTH-1:0]}));
      default: op_a = '0;
    endcase
    unique case (ctrl.mul_b)
      MB_M0:   op_b = mul_t'(mom_r[0]);
      MB_M1:   op_b = mul_t'(mom_r[1]);
      MB_M2:   op_b = mul_t'(mom_r[2]);
      MB_GAIN: op_b = mul_t'($signed({1'b0, gain}));
      default: op_b = '0;
    endcase
  end

  assign prod_nxt = prod_t'(op_a) * prod_t'(op_b);

  // Cross product difference, each product floored by the pre-shift.
  assign prod_sh = prod_r >>> PRE_SHIFT;

  always_comb begin
    unique case (ctrl.d_op)
      D_LOAD:  d_nxt = diff_t'(prod_sh);
      D_SUB:   d_nxt = d_r - diff_t'(prod_sh);
      default: d_nxt = d_r;
    endcase
  end

  // Gain scaling in two partial products: high part shifted, then low part.
  assign prod_ext = acc_t'(prod_r);

  always_comb begin
    unique case (ctrl.a_op)
      A_LOAD_HI: acc_nxt = prod_ext <<< DATA_WIDTH;
      A_ADD:     acc_nxt = acc_r + prod_ext;
      default:   acc_nxt = acc_r;
    endcase
  end

  // Negate, round half up and saturate to the sample range.
  assign rnd_sum = RND_HALF - rnd_t'(acc_r);
  assign rnd_sh  = rnd_sum >>> POST_SHIFT;

  always_comb begin
    if (rnd_sh > SAT_MAX) begin
      sat_val = SAT_MAX[DATA_WIDTH-1:0];
    end else if (rnd_sh < SAT_MIN) begin
      sat_val = SAT_MIN[DATA_WIDTH-1:0];
    end else begin
      sat_val = rnd_sh[DATA_WIDTH-1:0];
    end
  end

  // Dipole registers: cleared at program start, written one axis at a time.
  always_comb begin
    dip_nxt[0] = dip_r[0];
    dip_nxt[1] = dip_r[1];
    dip_nxt[2] = dip_r[2];
    if (ctrl.dip_clr) begin
      dip_nxt[0] = '0;
      dip_nxt[1] = '0;
      dip_nxt[2] = '0;
    end else if (ctrl.dip_wr) begin
      unique case (ctrl.axis)
        AX_X:    dip_nxt[0] = sat_val;
        AX_Y:    dip_nxt[1] = sat_val;
        AX_Z:    dip_nxt[2] = sat_val;
        default: dip_nxt[0] = dip_r[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    d_r      <= d_nxt;
    acc_r    <= acc_nxt;
    dip_r[0] <= dip_nxt[0];
    dip_r[1] <= dip_nxt[1];
    dip_r[2] <= dip_nxt[2];
  end

  assign dip_x = dip_r[0];
  assign dip_y = dip_r[1];
  assign dip_z = dip_r[2];

endmodule

@@ hw/rtl/momentum_desaturation_torquer_core.sv @@
`timescale 1ns / 1ps
// A transaction whose dipole is zero (idle or measuring) skips from step zero to the
// final step; otherwise the 18-step microprogram runs on the single shared multiplier.
// A new transaction is taken only once the sequencer is no longer busy with the
// last one.
// Reset (rst_n low, synchronous): configuration returns to its defaults and the
// engaged flag, held field and phase counter clear.
// ----------------------------------------------------------------------------
// momentum_desaturation_torquer_core
// Magnetorquer momentum dumping: hysteresis on wheel momentum, a duty cycle
// with a field measurement window, and a saturated -gain * (B x h) dipole.
// ----------------------------------------------------------------------------
module momentum_desaturation_torquer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mdt_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mdt_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [mdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mdt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mdt_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic [THR_W-1:0]  on_thr_r;
  logic [THR_W-1:0]  off_thr_r;
  logic [TICK_W-1:0] period_r;
  logic [TICK_W-1:0] measure_r;
  logic [TICK_W-1:0] phase_r, phase_nxt;
  logic              engaged_r, engaged_nxt;
  logic              measuring_r, measuring_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [TICK_W-1:0] eff_period;
  logic [TICK_W-1:0] phase;
  logic [TICK_W:0]   phase_inc;
  logic              in_window;
  logic              accept;
  logic              any_on, any_off;
  sample_t           mom [3];
  logic [CMP_W-1:0]  mag [3];

  ctrl_t             ctrl;
  seq_stat_t         stat;
  sample_t           dip_x, dip_y, dip_z;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_W'(256);
      on_thr_r  <= THR_W'(16384);
      off_thr_r <= THR_W'(8192);
      period_r  <= TICK_W'(100);
      measure_r <= TICK_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:    gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_ON_THR:  on_thr_r  <= cfg_wdata[THR_W-1:0];
        REG_OFF_THR: off_thr_r <= cfg_wdata[THR_W-1:0];
        REG_PERIOD:  period_r  <= cfg_wdata[TICK_W-1:0];
        REG_MEASURE: measure_r <= cfg_wdata[TICK_W-1:0];
        default:     gain_r    <= gain_r;
      endcase
    end
  end

  assign in_ready = !stat.busy;
  assign accept   = in_valid && in_ready;

  // Momentum magnitudes against the hysteresis thresholds.
  assign mom[0] = in_data.momentum_x;
  assign mom[1] = in_data.momentum_y;
  assign mom[2] = in_data.momentum_z;

  always_comb begin
    any_on  = 1'b0;
    any_off = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mom[i][DATA_WIDTH-1] ? CMP_W'(-{1'b0, mom[i]}) : CMP_W'({1'b0, mom[i]});
      if (mag[i] > CMP_W'(on_thr_r)) begin
        any_on = 1'b1;
      end
      if (mag[i] > CMP_W'(off_thr_r)) begin
        any_off = 1'b1;
      end
    end
  end

  // Duty cycle phase; a stale phase from a lowered period counts as zero.
  assign eff_period = (period_r == '0) ? TICK_W'(1) : period_r;
  assign phase      = (phase_r < eff_period) ? phase_r : '0;
  assign phase_inc  = {1'b0, phase} + (TICK_W+1)'(1);
  assign in_window  = phase < measure_r;

  always_comb begin
    engaged_nxt   = engaged_r;
    measuring_nxt = measuring_r;
    phase_nxt     = phase_r;
    if (accept) begin
      engaged_nxt   = (engaged_r && any_off) || any_on;
      measuring_nxt = engaged_nxt && in_window;
      phase_nxt     = (phase_inc >= {1'b0, eff_period}) ? '0 : phase_inc[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engaged_r   <= 1'b0;
      measuring_r <= 1'b0;
      phase_r     <= '0;
    end else begin
      engaged_r   <= engaged_nxt;
      measuring_r <= measuring_nxt;
      phase_r     <= phase_nxt;
    end
  end

  mdt_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .skip     (!engaged_r || measuring_r),
    .out_free (!out_valid_r || out_ready),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  mdt_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .ld_mom  (accept),
    .ld_held (accept && measuring_nxt),
    .gain    (gain_r),
    .ctrl    (ctrl),
    .dip_x   (dip_x),
    .dip_y   (dip_y),
    .dip_z   (dip_z)
  );

  // Result register; a finished transaction waits here for the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.finish) begin
      out_data_r.dipole_x  <= dip_x;
      out_data_r.dipole_y  <= dip_y;
      out_data_r.dipole_z  <= dip_z;
      out_data_r.active    <= engaged_r;
      out_data_r.measuring <= measuring_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
